// File: design/inv3_pkg.sv
`timescale 1ns / 1ps

package inv3_pkg;

  // Entry format: signed fixed point, EntryW bits with FracW fraction bits.
  localparam int EntryW = 32;
  localparam int FracW  = 16;

  // Widths of the exact intermediate values.
  localparam int ProdW  = 2 * EntryW;               // entry times entry
  localparam int AdjW   = 2 * EntryW + 1;           // cofactor
  localparam int PartW  = 2 * EntryW + 1;           // entry times half a cofactor
  localparam int DetW   = 3 * EntryW + 3;           // determinant
  localparam int DivW   = 2 * EntryW + 4 * FracW + 4;  // dividend and shifted divisor
  localparam int QuotW  = EntryW + 2;               // quotient bits kept
  localparam int NumDiv = QuotW;                    // one divider stage per quotient bit

  typedef logic signed [EntryW-1:0] entry_t;

  // Nine entries in row-major order, first entry in the upper bits.
  typedef logic [8:0][EntryW-1:0] mat_t;

  typedef struct packed {
    entry_t in_r0c0;
    entry_t in_r0c1;
    entry_t in_r0c2;
    entry_t in_r1c0;
    entry_t in_r1c1;
    entry_t in_r1c2;
    entry_t in_r2c0;
    entry_t in_r2c1;
    entry_t in_r2c2;
  } inv3_in_t;

  typedef struct packed {
    entry_t out_r0c0;
    entry_t out_r0c1;
    entry_t out_r0c2;
    entry_t out_r1c0;
    entry_t out_r1c1;
    entry_t out_r1c2;
    entry_t out_r2c0;
    entry_t out_r2c1;
    entry_t out_r2c2;
    logic   singular;
    logic   saturated;
  } inv3_out_t;

endpackage

// File: design/inverse_3x3_matrix.sv
`timescale 1ns / 1ps

// 3x3 matrix inverse by the adjugate, signed Q16.16 entries.
// Input channel: in_valid_i / in_stall_o carry one matrix per beat in
// in_data_i, row-major. Output channel: out_valid_o / out_stall_i carry the
// inverse, a singular flag and a saturated flag in out_data_o.
// Each entry is round(adj * 2^32 / det), ties away from zero, clamped to
// the 32-bit range. A zero determinant, or one so large that its reciprocal
// rounds to zero, returns the input matrix with singular set.
// Six stages compute the products, cofactors, determinant and operand
// setup, then 34 restoring divider stages (one quotient bit each, nine
// lanes in parallel), then one output register. Throughput is one matrix
// per cycle while the receiver does not stall; the 132-bit compare and
// subtract of one divider stage sets the clock.
// Reset clears every stage's valid bit; data registers are not reset.
// When the receiver stalls, the result holds in the output register and
// empty stages further back still fill, so the block keeps taking beats
// until the pipeline is full; then in_stall_o rises. Nothing is lost or
// repeated.
module inverse_3x3_matrix import inv3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  inv3_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output inv3_out_t out_data_o
);

  localparam int DivBase = 6;
  localparam int NS      = DivBase + NumDiv + 1;
  localparam int OutStg  = NS - 1;

  // Operand pairs of the nine cofactors, in adjugate order.
  localparam int Pick [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  localparam logic [DetW-1:0] DetLim = {{(DetW-1){1'b0}}, 1'b1} << (4 * FracW + 1);

  // Pipeline control: a stage loads when it is empty or its successor moves.
  logic [NS-1:0] v_q, v_d, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = (en & {v_q[NS-2:0], in_valid_i}) | (~en & v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[OutStg];

  // The input matrix travels with each beat for the singular case.
  mat_t in_q [NS-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      in_q[0] <= mat_t'(in_data_i);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        in_q[k] <= in_q[k-1];
      end
    end
  end

  // Stage 0: the eighteen entry products.
  mat_t   min;
  entry_t ein [9];
  logic signed [ProdW-1:0] pa_q [9], pb_q [9];

  assign min = mat_t'(in_data_i);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ein[k] = $signed(min[8-k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= ein[Pick[k][0]] * ein[Pick[k][1]];
        pb_q[k] <= ein[Pick[k][2]] * ein[Pick[k][3]];
      end
    end
  end

  // Stage 1: cofactors.
  logic signed [AdjW-1:0] adj1_q [9], adj2_q [9], adj3_q [9];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 9; k++) begin
        adj1_q[k] <= AdjW'(pa_q[k]) - AdjW'(pb_q[k]);
      end
    end
  end

  // Stage 2: first row times its cofactors, each split into a low and high half.
  logic signed [PartW-1:0] pl_q [3], ph_q [3];
  logic signed [EntryW:0]  lo_s [3], hi_s [3];
  entry_t                  erow [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      erow[i] = $signed(in_q[1][8-i]);
      lo_s[i] = $signed({1'b0, adj1_q[3*i][EntryW-1:0]});
      hi_s[i] = adj1_q[3*i][AdjW-1:EntryW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i] <= erow[i] * lo_s[i];
        ph_q[i] <= erow[i] * hi_s[i];
      end
      adj2_q <= adj1_q;
    end
  end

  // Stage 3: determinant.
  logic signed [DetW-1:0] det_d, det_q;

  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) begin
      det_d = det_d + (DetW'(ph_q[i]) <<< EntryW) + DetW'(pl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      det_q  <= det_d;
      adj3_q <= adj2_q;
    end
  end

  // Stage 4: magnitudes and result signs.
  logic [DetW-1:0] adet_q;
  logic [AdjW-1:0] aadj_q [9];
  logic [8:0]      neg4_q;
  logic            dz_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      adet_q <= det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);
      dz_q   <= (det_q == '0);
      for (int k = 0; k < 9; k++) begin
        aadj_q[k] <= adj3_q[k][AdjW-1] ? AdjW'(-adj3_q[k]) : AdjW'(adj3_q[k]);
        neg4_q[k] <= adj3_q[k][AdjW-1] ^ det_q[DetW-1];
      end
    end
  end

  // Stage 5: singular test and divider operands (rounding folded into the dividend).
  logic [DivW-1:0] num5_q [9];
  logic [DivW-1:0] den5_q;
  logic [8:0]      neg5_q;
  logic            sing5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sing5_q <= dz_q || (adet_q > DetLim);
      den5_q  <= DivW'(adet_q) << 1;
      neg5_q  <= neg4_q;
      for (int k = 0; k < 9; k++) begin
        num5_q[k] <= (DivW'(aadj_q[k]) << (2 * FracW + 1)) + DivW'(adet_q);
      end
    end
  end

  // Restoring divider: stage i settles quotient bit QuotW-1-i in all nine lanes.
  logic [DivW-1:0]  rem_q  [NumDiv][9];
  logic [QuotW-1:0] quo_q  [NumDiv][9];
  logic [DivW-1:0]  den_q  [NumDiv];
  logic [8:0]       neg_q  [NumDiv];
  logic             sing_q [NumDiv];

  for (genvar i = 0; i < NumDiv; i++) begin : g_div
    localparam int Sh = QuotW - 1 - i;

    logic [DivW-1:0]  rem_s [9];
    logic [QuotW-1:0] quo_s [9];
    logic [DivW-1:0]  den_s;
    logic [8:0]       neg_s;
    logic             sing_s;
    logic [DivW-1:0]  dsh;
    logic [DivW-1:0]  rem_n [9];
    logic [QuotW-1:0] quo_n [9];

    if (i == 0) begin : g_src0
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          rem_s[k] = num5_q[k];
          quo_s[k] = '0;
        end
        den_s  = den5_q;
        neg_s  = neg5_q;
        sing_s = sing5_q;
      end
    end else begin : g_srcn
      always_comb begin
        for (int k = 0; k < 9; k++) begin
          rem_s[k] = rem_q[i-1][k];
          quo_s[k] = quo_q[i-1][k];
        end
        den_s  = den_q[i-1];
        neg_s  = neg_q[i-1];
        sing_s = sing_q[i-1];
      end
    end

    // One compare and subtract per lane.
    always_comb begin
      dsh = den_s << Sh;
      for (int k = 0; k < 9; k++) begin
        quo_n[k] = quo_s[k];
        if (rem_s[k] >= dsh) begin
          rem_n[k]     = rem_s[k] - dsh;
          quo_n[k][Sh] = 1'b1;
        end else begin
          rem_n[k] = rem_s[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[DivBase+i]) begin
        for (int k = 0; k < 9; k++) begin
          rem_q[i][k] <= rem_n[k];
          quo_q[i][k] <= quo_n[k];
        end
        den_q[i]  <= den_s;
        neg_q[i]  <= neg_s;
        sing_q[i] <= sing_s;
      end
    end
  end

  // Output stage: sign, saturation and the singular bypass.
  mat_t        res_m;
  logic [8:0]  clip;
  inv3_out_t   out_d, out_q;

  always_comb begin
    logic [QuotW-1:0] mag;
    logic             pos_ovf, neg_ovf;
    for (int k = 0; k < 9; k++) begin
      mag     = quo_q[NumDiv-1][k];
      pos_ovf = (mag[QuotW-1:EntryW-1] != '0);
      neg_ovf = (mag[QuotW-1:EntryW] != '0) ||
                (mag[EntryW-1] && (mag[EntryW-2:0] != '0));
      if (!neg_q[NumDiv-1][k]) begin
        clip[k]      = pos_ovf;
        res_m[8-k]   = pos_ovf ? {1'b0, {(EntryW-1){1'b1}}} : mag[EntryW-1:0];
      end else begin
        clip[k]      = neg_ovf;
        res_m[8-k]   = neg_ovf ? {1'b1, {(EntryW-1){1'b0}}} : EntryW'(-mag[EntryW-1:0]);
      end
    end
    if (sing_q[NumDiv-1]) begin
      out_d = inv3_out_t'({in_q[NS-2], 1'b1, 1'b0});
    end else begin
      out_d = inv3_out_t'({res_m, 1'b0, |clip});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutStg]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: tb/inv3_checker.sv
`timescale 1ns / 1ps

module inv3_checker import inv3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_o,
  input  inv3_in_t  in_data_i,
  input  logic      out_valid_o,
  input  logic      out_stall_i,
  input  inv3_out_t out_data_o,
  output int        fail_count_o,
  output int        pending_o
);

  typedef logic signed [255:0] wide_t;

  inv3_out_t inverse_q[$];

  // Exact adjugate inverse with round half away from zero and saturation.
  function automatic inv3_out_t predict_inverse(inv3_in_t m);
    wide_t      e [9];
    wide_t      cof [9];
    wide_t      det, adet, lim, num, quo, maxpos, minneg;
    inv3_out_t  r;
    logic [8:0][EntryW-1:0] res;
    logic       sat;
    int         k;
    e[0] = m.in_r0c0; e[1] = m.in_r0c1; e[2] = m.in_r0c2;
    e[3] = m.in_r1c0; e[4] = m.in_r1c1; e[5] = m.in_r1c2;
    e[6] = m.in_r2c0; e[7] = m.in_r2c1; e[8] = m.in_r2c2;
    cof[0] = e[4]*e[8] - e[5]*e[7];
    cof[1] = e[2]*e[7] - e[1]*e[8];
    cof[2] = e[1]*e[5] - e[2]*e[4];
    cof[3] = e[5]*e[6] - e[3]*e[8];
    cof[4] = e[0]*e[8] - e[2]*e[6];
    cof[5] = e[2]*e[3] - e[0]*e[5];
    cof[6] = e[3]*e[7] - e[4]*e[6];
    cof[7] = e[1]*e[6] - e[0]*e[7];
    cof[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
    adet = (det < 0) ? -det : det;
    lim = wide_t'(1) <<< (4*FracW + 1);
    maxpos = (wide_t'(1) <<< (EntryW-1)) - 1;
    minneg = -(wide_t'(1) <<< (EntryW-1));
    if (det == 0 || adet > lim) begin
      // Singular: the input entries come back with the singular flag set.
      r = {m, 1'b1, 1'b0};
      return r;
    end
    sat = 1'b0;
    for (k = 0; k < 9; k++) begin
      num = (cof[k] < 0) ? -cof[k] : cof[k];
      quo = ((num <<< (2*FracW + 1)) + adet) / (adet <<< 1);
      if ((cof[k] < 0) != (det < 0)) quo = -quo;
      if (quo > maxpos) begin
        quo = maxpos; sat = 1'b1;
      end else if (quo < minneg) begin
        quo = minneg; sat = 1'b1;
      end
      res[8-k] = quo[EntryW-1:0];
    end
    r = {res, 1'b0, sat};
    return r;
  endfunction

  // Compare one field of a result beat.
  task automatic check_field(string name, logic [EntryW-1:0] exp_v,
                             logic [EntryW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial fail_count_o = 0;
  assign pending_o = inverse_q.size();

  always @(posedge clk_i) begin
    inv3_out_t want;
    if (rst_ni && in_valid_i && !in_stall_o) inverse_q.push_back(predict_inverse(in_data_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $error("result beat with no matrix outstanding");
        fail_count_o++;
      end else begin
        want = inverse_q.pop_front();
        check_field("out_r0c0", want.out_r0c0, out_data_o.out_r0c0);
        check_field("out_r0c1", want.out_r0c1, out_data_o.out_r0c1);
        check_field("out_r0c2", want.out_r0c2, out_data_o.out_r0c2);
        check_field("out_r1c0", want.out_r1c0, out_data_o.out_r1c0);
        check_field("out_r1c1", want.out_r1c1, out_data_o.out_r1c1);
        check_field("out_r1c2", want.out_r1c2, out_data_o.out_r1c2);
        check_field("out_r2c0", want.out_r2c0, out_data_o.out_r2c0);
        check_field("out_r2c1", want.out_r2c1, out_data_o.out_r2c1);
        check_field("out_r2c2", want.out_r2c2, out_data_o.out_r2c2);
        check_field("singular", EntryW'(want.singular), EntryW'(out_data_o.singular));
        check_field("saturated", EntryW'(want.saturated), EntryW'(out_data_o.saturated));
      end
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench import inv3_pkg::*;;

  localparam int Latency = 41;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  inv3_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  inv3_out_t out_data_o;
  int        fail_count;
  int        pending;
  bit        hold_out = 1'b0;
  bit        calm = 1'b0;

  inverse_3x3_matrix i_dut (.*);

  inv3_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver stall: random, except during the calm stretch or a long hold-off.
  always @(posedge clk_i) begin
    if (hold_out) begin
      out_stall_i <= 1'b1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 35);
    end
  end

  // Q16.16 value of a small integer.
  function automatic entry_t fix(int v);
    return entry_t'(v) <<< FracW;
  endfunction

  function automatic entry_t rand_entry();
    case ($urandom_range(5))
      0: return entry_t'($urandom);
      1: return entry_t'($signed($urandom_range(1 << 20)) - (1 << 19));
      2: return fix($urandom_range(8)) - fix(4);
      3: return entry_t'($urandom_range(3)) - 1;
      4: return $urandom_range(1) ? entry_t'(32'h7fffffff) : entry_t'(32'h80000000);
      default: return fix($urandom_range(200)) - fix(100) + entry_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic inv3_in_t rand_matrix();
    inv3_in_t m;
    m = {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
         rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // Some matrices with a repeated row, so the determinant is zero.
    if ($urandom_range(9) == 0) begin
      m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
    end
    return m;
  endfunction

  // Offer one matrix beat and wait until it is taken.
  task automatic send_matrix(inv3_in_t m, bit gaps);
    while (gaps && !calm && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    inv3_in_t m;
    inv3_in_t directed[$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity, scaled identity, tiny and huge values, singular cases.
    directed.push_back({fix(1), fix(0), fix(0), fix(0), fix(1), fix(0), fix(0), fix(0), fix(1)});
    directed.push_back({fix(2), fix(0), fix(0), fix(0), -fix(4), fix(0), fix(0), fix(0), fix(8)});
    directed.push_back({fix(1), fix(2), fix(3), fix(0), fix(1), fix(4), fix(5), fix(6), fix(0)});
    directed.push_back({fix(1), fix(2), fix(3), fix(4), fix(5), fix(6), fix(7), fix(8), fix(9)});
    directed.push_back('0);
    directed.push_back('1);
    directed.push_back({32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1});
    directed.push_back({32'sh7fffffff, 32'sd0, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sd0,
                        32'sd0, 32'sd0, 32'sh7fffffff});
    directed.push_back({32'sh80000000, 32'sd0, 32'sd0, 32'sd0, 32'sh80000000, 32'sd0,
                        32'sd0, 32'sd0, 32'sh80000000});
    directed.push_back({32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7fffffff});
    directed.push_back({fix(256), fix(0), fix(0), fix(0), fix(256), fix(0), fix(0), fix(0),
                        fix(256)});
    directed.push_back({fix(256), fix(0), fix(0), fix(0), fix(256), fix(0), fix(0), fix(0),
                        fix(257)});
    directed.push_back({32'sd256, 32'sd0, 32'sd0, 32'sd0, 32'sd256, 32'sd0, 32'sd0, 32'sd0,
                        32'sd256});
    directed.push_back({32'sd3, 32'sd1, 32'sd0, 32'sd1, 32'sd3, 32'sd0, 32'sd0, 32'sd0,
                        -32'sd1});
    directed.push_back({fix(3), fix(0), fix(0), fix(0), fix(3), fix(0), fix(0), fix(0),
                        -fix(3)});
    foreach (directed[i]) send_matrix(directed[i], 1'b0);

    // Random matrices with idle gaps.
    for (int n = 0; n < 1450; n++) begin
      m = rand_matrix();
      if (n == 300) calm = 1'b1;
      if (n == 420) calm = 1'b0;
      if (n == 600) begin
        // Long receiver hold-off while matrices keep coming.
        hold_out = 1'b1;
        fork
          begin
            repeat (150) @(posedge clk_i);
            hold_out = 1'b0;
          end
        join_none
      end
      if (n == 900) drain();
      send_matrix(m, 1'b1);
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: inverse_3x3_matrix.f
design/inv3_pkg.sv
design/inverse_3x3_matrix.sv
tb/inv3_checker.sv
tb/testbench.sv
